/* src/gdad_pkg.sv */
// Shared constants, types and calendar functions for the Gregorian date shifter.
package gdad_pkg;

  // Default width of the signed day offset.
  localparam int GDAD_DELTA_BITS = 16;

  // Packed field widths.
  localparam int CODE_BITS  = 27;
  localparam int YEAR_BITS  = 14;
  localparam int MONTH_BITS = 4;
  localparam int DAY_BITS   = 7;
  localparam int YMOD_BITS  = 9;
  localparam int DIV_BITS   = 14;
  localparam int RECIP_BITS = 27;
  localparam int SHIFT_BITS = 6;

  // Days in a full 400-year Gregorian cycle.
  localparam int GDAD_SPAN_DAYS = 146097;

  // Divisors used when unpacking the date code.
  localparam logic [DIV_BITS-1:0] DIV_YEAR  = 14'd10000;
  localparam logic [DIV_BITS-1:0] DIV_MONTH = 14'd100;
  localparam logic [DIV_BITS-1:0] DIV_CYCLE = 14'd400;

  // Scaled reciprocals: (n * recip) >> shift equals n / divisor over each operand range
  // (any 27-bit code for the year, below 10000 for the month, any 14-bit year for the cycle).
  localparam logic [RECIP_BITS-1:0] RECIP_YEAR  = 27'd109951163;
  localparam logic [SHIFT_BITS-1:0] SHIFT_YEAR  = 6'd40;
  localparam logic [RECIP_BITS-1:0] RECIP_MONTH = 27'd5243;
  localparam logic [SHIFT_BITS-1:0] SHIFT_MONTH = 6'd19;
  localparam logic [RECIP_BITS-1:0] RECIP_CYCLE = 27'd5243;
  localparam logic [SHIFT_BITS-1:0] SHIFT_CYCLE = 6'd21;

  // Clamped results when the year leaves its range.
  localparam logic [CODE_BITS-1:0] DATE_MIN = 27'd101;
  localparam logic [CODE_BITS-1:0] DATE_MAX = 27'd99991231;
  localparam int YEAR_LAST = 9999;

  // Month constants: both ends of the year and February.
  localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

  // Last position within the 400-year cycle.
  localparam logic [YMOD_BITS-1:0] YMOD_LAST = 9'd399;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV_Y = 6'b000010,
    ST_DIV_M = 6'b000100,
    ST_DIV_L = 6'b001000,
    ST_NORM  = 6'b010000,
    ST_PACK  = 6'b100000
  } state_t;

  // Year adjustment requested by one normalisation step.
  typedef enum logic [2:0] {
    YS_NONE,
    YS_INC,
    YS_DEC,
    YS_INC400,
    YS_DEC400
  } ystep_t;

  // Control result of one normalisation step.
  typedef struct packed {
    logic                  done;
    logic [MONTH_BITS-1:0] month_nxt;
    ystep_t                ystep;
  } norm_step_t;

  // Leap year from the position of the year within its 400-year cycle.
  function automatic logic is_leap(input logic [YMOD_BITS-1:0] ymod);
    logic century;
    century = (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
    return (ymod[1:0] == 2'b00) && !century;
  endfunction

  // Length of a month in days.
  function automatic logic [4:0] days_per_month(input logic [MONTH_BITS-1:0] month,
                                                input logic leap);
    logic [4:0] n;
    unique case (month) inside
      MONTH_FEB:                 n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

/* src/gregorian_date_add_days.sv */
// Top level of the Gregorian date shifter: sequencer, registers and result stage.
//
// Usage: an item on the input channel carries a packed date code
// (year*10000 + month*100 + day) and a signed day offset. The block returns one
// result per item: the shifted, normalised date code with a bad-month flag and
// a year-overflow flag. Both channels are valid/ready; a transfer takes place
// when valid and ready are high at a rising edge.
// The shared reciprocal divider unpacks year, month and day and the year's
// place in its 400-year cycle in three divisions, each registering its
// quotient and then taking the remainder. The shared day adder then makes
// one normalisation step at a time (one per 400-year span, then one per month
// crossed) plus one final check, and the pack step fills the result
// register. A bad month skips the last division and the normalisation.
// in_ready is high only while the sequencer is idle, so no new item is taken
// before the last one has been packed; a 16-bit offset crosses up to about
// 1080 months. The result register holds a finished result while the
// receiver stalls; a new item is taken meanwhile, and its result waits in
// the pack step until the register frees. Synchronous reset clears the
// sequencer and out_valid.
module gregorian_date_add_days
  import gdad_pkg::*;
#(
  parameter int DELTA_BITS = GDAD_DELTA_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [CODE_BITS-1:0]         in_date_code,
  input  logic signed [DELTA_BITS-1:0] in_day_delta,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [CODE_BITS-1:0]         out_result_code,
  output logic                         out_bad_month,
  output logic                         out_year_overflow
);

  // Working width for days and years, wide enough for any offset.
  localparam int W = ((DELTA_BITS > 18) ? DELTA_BITS : 18) + 2;
  localparam logic signed [W-1:0] YEAR_MAX = W'(YEAR_LAST);

  state_t                state_r, state_nxt;
  logic                  qdone_r, qdone_nxt;
  logic [CODE_BITS-1:0]  rem_r, rem_nxt;
  logic [YEAR_BITS-1:0]  q_r, q_nxt;
  logic [CODE_BITS-1:0]  code_r, code_nxt;
  logic signed [W-1:0]   delta_r, delta_nxt;
  logic signed [W-1:0]   year_r, year_nxt;
  logic signed [W-1:0]   day_r, day_nxt;
  logic [MONTH_BITS-1:0] month_r, month_nxt;
  logic [YMOD_BITS-1:0]  ymod_r, ymod_nxt;
  logic                  bad_r, bad_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CODE_BITS-1:0]  res_code_r, res_code_nxt;
  logic                  res_bad_r, res_bad_nxt;
  logic                  res_ovf_r, res_ovf_nxt;

  logic [DIV_BITS-1:0]   divisor;
  logic [RECIP_BITS-1:0] div_recip;
  logic [SHIFT_BITS-1:0] div_shift;
  logic [YEAR_BITS-1:0]  div_quot;
  logic [CODE_BITS-1:0]  div_rem;
  logic [6:0]            month_q;
  logic signed [W-1:0]   norm_day;
  norm_step_t            norm_step;
  logic                  out_free;
  logic [CODE_BITS-1:0]  packed_code;

  // Divisor and reciprocal for the current unpacking phase.
  always_comb begin
    unique case (state_r)
      ST_DIV_M: begin
        divisor   = DIV_MONTH;
        div_recip = RECIP_MONTH;
        div_shift = SHIFT_MONTH;
      end
      ST_DIV_L: begin
        divisor   = DIV_CYCLE;
        div_recip = RECIP_CYCLE;
        div_shift = SHIFT_CYCLE;
      end
      default: begin
        divisor   = DIV_YEAR;
        div_recip = RECIP_YEAR;
        div_shift = SHIFT_YEAR;
      end
    endcase
  end

  gdad_div_unit u_div (
    .num_i     (rem_r),
    .divisor_i (divisor),
    .recip_i   (div_recip),
    .shift_i   (div_shift),
    .quot_i    (q_r),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  gdad_norm_unit #(
    .W (W)
  ) u_norm (
    .day_i   (day_r),
    .month_i (month_r),
    .ymod_i  (ymod_r),
    .day_o   (norm_day),
    .step_o  (norm_step)
  );

  assign month_q  = q_r[6:0];
  assign out_free = !out_valid_r || out_ready;

  // Pack the normalised date; the year is known to be in range here.
  assign packed_code = CODE_BITS'(year_r[YEAR_BITS-1:0]) * CODE_BITS'(10000)
                     + CODE_BITS'(month_r) * CODE_BITS'(100)
                     + CODE_BITS'(day_r[DAY_BITS-1:0]);

  // Sequencer and datapath register updates. Each division registers its
  // quotient and then takes the remainder from the registered quotient.
  always_comb begin
    state_nxt     = state_r;
    qdone_nxt     = qdone_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    code_nxt      = code_r;
    delta_nxt     = delta_r;
    year_nxt      = year_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    ymod_nxt      = ymod_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_code_nxt  = res_code_r;
    res_bad_nxt   = res_bad_r;
    res_ovf_nxt   = res_ovf_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          code_nxt  = in_date_code;
          rem_nxt   = in_date_code;
          delta_nxt = {{(W-DELTA_BITS){in_day_delta[DELTA_BITS-1]}}, in_day_delta};
          q_nxt     = '0;
          qdone_nxt = 1'b0;
          state_nxt = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (!qdone_r) begin
          q_nxt     = div_quot;
          qdone_nxt = 1'b1;
        end else begin
          year_nxt  = $signed({{(W-YEAR_BITS){1'b0}}, q_r});
          rem_nxt   = div_rem;
          qdone_nxt = 1'b0;
          state_nxt = ST_DIV_M;
        end
      end
      ST_DIV_M: begin
        if (!qdone_r) begin
          q_nxt     = div_quot;
          qdone_nxt = 1'b1;
        end else begin
          month_nxt = month_q[MONTH_BITS-1:0];
          day_nxt   = $signed({{(W-DAY_BITS){1'b0}}, div_rem[DAY_BITS-1:0]}) + delta_r;
          bad_nxt   = (month_q < 7'd1) || (month_q > 7'd12);
          rem_nxt   = CODE_BITS'(year_r[YEAR_BITS-1:0]);
          qdone_nxt = 1'b0;
          state_nxt = bad_nxt ? ST_PACK : ST_DIV_L;
        end
      end
      ST_DIV_L: begin
        if (!qdone_r) begin
          q_nxt     = div_quot;
          qdone_nxt = 1'b1;
        end else begin
          ymod_nxt  = div_rem[YMOD_BITS-1:0];
          qdone_nxt = 1'b0;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_step.done) begin
          state_nxt = ST_PACK;
        end else begin
          day_nxt   = norm_day;
          month_nxt = norm_step.month_nxt;
          case (norm_step.ystep)
            YS_INC: begin
              year_nxt = year_r + W'(1);
              ymod_nxt = (ymod_r == YMOD_LAST) ? '0 : ymod_r + 9'd1;
            end
            YS_DEC: begin
              year_nxt = year_r - W'(1);
              ymod_nxt = (ymod_r == '0) ? YMOD_LAST : ymod_r - 9'd1;
            end
            YS_INC400: year_nxt = year_r + W'(400);
            YS_DEC400: year_nxt = year_r - W'(400);
            default:   year_nxt = year_r;
          endcase
        end
      end
      ST_PACK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_bad_nxt   = bad_r;
          if (bad_r) begin
            res_code_nxt = code_r;
            res_ovf_nxt  = 1'b0;
          end else if (year_r < 0) begin
            res_code_nxt = DATE_MIN;
            res_ovf_nxt  = 1'b1;
          end else if (year_r > YEAR_MAX) begin
            res_code_nxt = DATE_MAX;
            res_ovf_nxt  = 1'b1;
          end else begin
            res_code_nxt = packed_code;
            res_ovf_nxt  = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      qdone_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      qdone_r     <= qdone_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    code_r     <= code_nxt;
    delta_r    <= delta_nxt;
    year_r     <= year_nxt;
    day_r      <= day_nxt;
    month_r    <= month_nxt;
    ymod_r     <= ymod_nxt;
    bad_r      <= bad_nxt;
    res_code_r <= res_code_nxt;
    res_bad_r  <= res_bad_nxt;
    res_ovf_r  <= res_ovf_nxt;
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_result_code   = res_code_r;
  assign out_bad_month     = res_bad_r;
  assign out_year_overflow = res_ovf_r;

endmodule

/* src/gdad_div_unit.sv */
// Division by a constant through a scaled reciprocal, with the matching remainder.
module gdad_div_unit
  import gdad_pkg::*;
(
  input  logic [CODE_BITS-1:0]  num_i,
  input  logic [DIV_BITS-1:0]   divisor_i,
  input  logic [RECIP_BITS-1:0] recip_i,
  input  logic [SHIFT_BITS-1:0] shift_i,
  input  logic [YEAR_BITS-1:0]  quot_i,
  output logic [YEAR_BITS-1:0]  quot_o,
  output logic [CODE_BITS-1:0]  rem_o
);

  localparam int PROD_BITS = CODE_BITS + RECIP_BITS;

  logic [PROD_BITS-1:0] prod;
  logic [CODE_BITS-1:0] back;

  // Quotient: multiply by the reciprocal and drop the scaling bits.
  assign prod   = PROD_BITS'(num_i) * PROD_BITS'(recip_i);
  assign quot_o = YEAR_BITS'(prod >> shift_i);

  // Remainder from the quotient registered on the cycle before.
  assign back  = CODE_BITS'(quot_i) * CODE_BITS'(divisor_i);
  assign rem_o = num_i - back;

endmodule

/* src/gdad_norm_unit.sv */
// One normalisation step: a 400-year span or a single month, through one adder.
module gdad_norm_unit
  import gdad_pkg::*;
#(
  parameter int W = 20
) (
  input  logic signed [W-1:0]          day_i,
  input  logic        [MONTH_BITS-1:0] month_i,
  input  logic        [YMOD_BITS-1:0]  ymod_i,
  output logic signed [W-1:0]          day_o,
  output norm_step_t                   step_o
);

  localparam logic signed [W-1:0] SPAN     = W'(GDAD_SPAN_DAYS);
  localparam logic signed [W-1:0] NEG_SPAN = -SPAN;
  localparam logic signed [W-1:0] ONE      = W'(1);

  logic                  leap_cur;
  logic                  leap_prev;
  logic [4:0]            dim_cur;
  logic [4:0]            dim_prev;
  logic [MONTH_BITS-1:0] month_prev;
  logic [YMOD_BITS-1:0]  ymod_prev;
  logic signed [W-1:0]   dim_cur_s;
  logic signed [W-1:0]   dim_prev_s;
  logic signed [W-1:0]   addend;

  // Month lengths for the current month and the one before it.
  assign month_prev = (month_i == MONTH_JAN) ? MONTH_DEC : month_i - 4'd1;
  assign ymod_prev  = (month_i != MONTH_JAN) ? ymod_i :
                      (ymod_i == '0) ? YMOD_LAST : ymod_i - 9'd1;
  assign leap_cur   = is_leap(ymod_i);
  assign leap_prev  = is_leap(ymod_prev);
  assign dim_cur    = days_per_month(month_i, leap_cur);
  assign dim_prev   = days_per_month(month_prev, leap_prev);
  assign dim_cur_s  = $signed({{(W-5){1'b0}}, dim_cur});
  assign dim_prev_s = $signed({{(W-5){1'b0}}, dim_prev});

  // Pick the step and the addend for the shared day adder.
  always_comb begin
    step_o.done      = 1'b0;
    step_o.month_nxt = month_i;
    step_o.ystep     = YS_NONE;
    addend           = '0;
    if (day_i > SPAN) begin
      addend       = NEG_SPAN;
      step_o.ystep = YS_INC400;
    end else if (day_i < NEG_SPAN) begin
      addend       = SPAN;
      step_o.ystep = YS_DEC400;
    end else if (day_i > dim_cur_s) begin
      addend = -dim_cur_s;
      if (month_i == MONTH_DEC) begin
        step_o.month_nxt = MONTH_JAN;
        step_o.ystep     = YS_INC;
      end else begin
        step_o.month_nxt = month_i + 4'd1;
      end
    end else if (day_i < ONE) begin
      addend           = dim_prev_s;
      step_o.month_nxt = month_prev;
      if (month_i == MONTH_JAN) begin
        step_o.ystep = YS_DEC;
      end
    end else begin
      step_o.done = 1'b1;
    end
  end

  assign day_o = day_i + addend;

endmodule

/* src/gdad_checker.sv */
// Port-level checks for the Gregorian date shifter, bound to the top level.
module gdad_checker
  import gdad_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CODE_BITS-1:0] out_result_code,
  input logic                 out_bad_month,
  input logic                 out_year_overflow
);

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // One item at a time: a transfer in closes the input until the item is done.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  // A bad month returns the input as is and never reports overflow.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_month |-> !out_year_overflow)
    else $error("bad month and year overflow flagged together");

  // An overflowed year gives one of the two clamped dates.
  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_year_overflow |->
      (out_result_code == DATE_MIN) || (out_result_code == DATE_MAX))
    else $error("overflowed result is not a clamped date");

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_code))
    else $error("stalled result changed");

endmodule

bind gregorian_date_add_days gdad_checker u_gdad_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_result_code   (out_result_code),
  .out_bad_month     (out_bad_month),
  .out_year_overflow (out_year_overflow)
);

/* tb/sv/gregorian_date_add_days_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the Gregorian date shifter, with its own calendar predictor.
module gregorian_date_add_days_tb;
  import gdad_pkg::*;

  localparam int DBITS       = GDAD_DELTA_BITS;
  localparam int STALL_LIMIT = 10000;
  localparam int TAIL_CYCLES = 1300;

  // One expected result: the shifted date and its two flags.
  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 bad_month;
    logic                 year_overflow;
  } shifted_date_t;

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic [CODE_BITS-1:0]    in_date_code = '0;
  logic signed [DBITS-1:0] in_day_delta = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic [CODE_BITS-1:0]    out_result_code;
  logic                    out_bad_month;
  logic                    out_year_overflow;

  // Results predicted for accepted items, oldest first.
  shifted_date_t pending_dates[$];
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles   = 0;
  int unsigned   stall_left     = 0;
  logic          idle_en        = 1'b1;

  gregorian_date_add_days #(
    .DELTA_BITS(DBITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_date_code     (in_date_code),
    .in_day_delta     (in_day_delta),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_code  (out_result_code),
    .out_bad_month    (out_bad_month),
    .out_year_overflow(out_year_overflow)
  );

  always #5 clk = ~clk;

  // Leap year by the 4/100/400 rule; works for negative years too.
  function automatic bit is_leap_year(input longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic longint month_length(input longint y, input longint m);
    longint n;
    case (m)
      2:           n = is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11: n = 30;
      default:     n = 31;
    endcase
    return n;
  endfunction

  // Works out the shifted date by stepping whole 400-year spans, then month by month.
  function automatic shifted_date_t shift_date(input logic [CODE_BITS-1:0] code,
                                               input logic signed [DBITS-1:0] delta);
    shifted_date_t r;
    longint        y;
    longint        m;
    longint        d;
    longint        dim;
    bit            settled;
    y = longint'(code) / 10000;
    m = (longint'(code) / 100) % 100;
    d = longint'(code) % 100;
    r.bad_month     = 1'b0;
    r.year_overflow = 1'b0;
    r.code          = code;
    if (m < MONTH_JAN || m > MONTH_DEC) begin
      r.bad_month = 1'b1;
      return r;
    end
    d = d + longint'(delta);
    while (d > GDAD_SPAN_DAYS) begin
      d = d - GDAD_SPAN_DAYS;
      y = y + 400;
    end
    while (d < -GDAD_SPAN_DAYS) begin
      d = d + GDAD_SPAN_DAYS;
      y = y - 400;
    end
    settled = 1'b0;
    while (!settled) begin
      dim = month_length(y, m);
      if (d > dim) begin
        d = d - dim;
        m = m + 1;
        if (m > MONTH_DEC) begin
          m = MONTH_JAN;
          y = y + 1;
        end
      end else if (d < 1) begin
        m = m - 1;
        if (m < MONTH_JAN) begin
          m = MONTH_DEC;
          y = y - 1;
        end
        d = d + month_length(y, m);
      end else begin
        settled = 1'b1;
      end
    end
    // Clamp when the year has left the four-digit range.
    if (y < 0) begin
      r.code          = DATE_MIN;
      r.year_overflow = 1'b1;
    end else if (y > YEAR_LAST) begin
      r.code          = DATE_MAX;
      r.year_overflow = 1'b1;
    end else begin
      r.code = CODE_BITS'(y * 10000 + m * 100 + d);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint expected,
                                 input longint actual);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, expected,
             actual);
    mismatch_count++;
  endtask

  // Offers one date for transfer, sometimes after a burst of idle cycles.
  // Valid is left high afterwards so that back-to-back items need no gap.
  task automatic send_date(input logic [CODE_BITS-1:0] code,
                           input logic signed [DBITS-1:0] delta);
    if (idle_en && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_date_code <= code;
    in_day_delta <= delta;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Receiver stalls in random bursts while idling is enabled.
  always @(posedge clk) begin
    if (!idle_en) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(5) == 0) begin
      stall_left <= $urandom_range(6);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Checks each result transfer against the oldest prediction, records each input
  // transfer, and ends the run if nothing moves for too long.
  always @(posedge clk) begin : transfer_monitor
    shifted_date_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_dates.size() == 0) begin
          report_mismatch("result with nothing pending", 0, longint'(out_result_code));
        end else begin
          want = pending_dates.pop_front();
          if (out_result_code !== want.code)
            report_mismatch("result_code", longint'(want.code), longint'(out_result_code));
          if (out_bad_month !== want.bad_month)
            report_mismatch("bad_month", longint'(want.bad_month), longint'(out_bad_month));
          if (out_year_overflow !== want.year_overflow)
            report_mismatch("year_overflow", longint'(want.year_overflow),
                            longint'(out_year_overflow));
        end
      end
      if (in_valid && in_ready) begin
        pending_dates.push_back(shift_date(in_date_code, in_day_delta));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Random packed date: mostly well-formed, some near the year limits, some noise.
  function automatic logic [CODE_BITS-1:0] random_date_code();
    int unsigned pick;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    pick = $urandom_range(19);
    if (pick == 0) return CODE_BITS'($urandom());
    if (pick <= 2) begin
      y = $urandom_range(1) ? $urandom_range(3) : YEAR_LAST - $urandom_range(3);
    end else if (pick == 3) begin
      y = $urandom_range(13420, YEAR_LAST + 1);
    end else begin
      y = $urandom_range(YEAR_LAST);
    end
    m = ($urandom_range(19) == 0) ? $urandom_range(99) : $urandom_range(MONTH_DEC, MONTH_JAN);
    d = ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(31, 1);
    return CODE_BITS'(y * 10000 + m * 100 + d);
  endfunction

  // Random offset: small, medium, full range or close to the extremes.
  function automatic logic signed [DBITS-1:0] random_delta();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick <= 3) return DBITS'(int'($urandom_range(200)) - 100);
    if (pick <= 6) return DBITS'($urandom());
    if (pick == 7) begin
      return $urandom_range(1) ? DBITS'(32767 - int'($urandom_range(3)))
                               : DBITS'(-32768 + int'($urandom_range(3)));
    end
    return DBITS'(int'($urandom_range(3000)) - 1500);
  endfunction

  // Month and year boundaries, leap rules, unnormalised days and offset extremes.
  task automatic test_month_ends();
    send_date(27'd20240228, DBITS'(1));
    send_date(27'd20230228, DBITS'(1));
    send_date(27'd19000228, DBITS'(1));
    send_date(27'd20000228, DBITS'(1));
    send_date(27'd20241231, DBITS'(1));
    send_date(27'd20250101, DBITS'(-1));
    send_date(27'd20240300, DBITS'(0));
    send_date(27'd20240132, DBITS'(0));
    send_date(27'd20240199, DBITS'(0));
    send_date(27'd20240615, DBITS'(32767));
    send_date(27'd20240615, DBITS'(-32768));
    send_date(27'd19991231, DBITS'(0));
  endtask

  // Months outside 1..12 pass the code through with the flag set.
  task automatic test_bad_months();
    send_date(27'd20240015, DBITS'(5));
    send_date(27'd20241301, DBITS'(-5));
    send_date(27'd99999999, DBITS'(32767));
    send_date(27'd0, DBITS'(-32768));
    send_date({CODE_BITS{1'b1}}, DBITS'(1));
  endtask

  // Results that fall off either end of the year range, and years above 9999 on input.
  task automatic test_year_limits();
    send_date(DATE_MIN, DBITS'(-1));
    send_date(DATE_MIN, DBITS'(-32768));
    send_date(DATE_MAX, DBITS'(1));
    send_date(DATE_MAX, DBITS'(32767));
    send_date(27'd134211231, DBITS'(0));
    send_date(27'd100000101, DBITS'(-32768));
  endtask

  task automatic test_random_shifts(input int unsigned count);
    repeat (count) send_date(random_date_code(), random_delta());
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_steady_stream(input int unsigned count);
    idle_en <= 1'b0;
    repeat (count) send_date(random_date_code(), random_delta());
  endtask

  // Stops offering items and waits for every pending result, then a tail.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_dates.size() != 0)
      report_mismatch("results still pending", 0, longint'(pending_dates.size()));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_month_ends();
    test_bad_months();
    test_year_limits();
    test_random_shifts(440);
    test_steady_stream(60);
    drain_results();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
